[rtl/core/kmm_pkg.sv]
`default_nettype none
package kmm_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int POS_W       = $clog2(MAX_PATTERN);
	localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
	localparam int CFG_W       = 7;
	localparam int SYM_W       = 8;
	localparam int ACT_W       = 2;
	localparam int IDX_W       = 1;
	localparam int GRP_N       = 8;
	localparam int NGRP        = (MAX_PATTERN + GRP_N - 1) / GRP_N;
	localparam int GRP_CNT_W   = $clog2(GRP_N + 1);
	localparam int FIELD_MAX   = 63;

	localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_TEXT    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

	localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH  = 1'b0;
	localparam logic [IDX_W-1:0] REG_ERROR_THRESHOLD = 1'b1;

	localparam logic [CFG_W-1:0] RST_PATTERN_LENGTH  = 7'd64;
	localparam logic [CFG_W-1:0] RST_ERROR_THRESHOLD = 7'd1;

	typedef struct packed {
		logic             is_load;
		logic [POS_W-1:0] position;
		logic [SYM_W-1:0] symbol;
		logic             emit;
	} kmm_op_t;

	function automatic logic [CNT_W-1:0] len_clamp(input logic [CFG_W-1:0] l);
		logic [CNT_W-1:0] r;
		if (l == '0) begin
			r = CNT_W'(1);
		end else if (32'(l) > MAX_PATTERN) begin
			r = CNT_W'(MAX_PATTERN);
		end else begin
			r = CNT_W'(l);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/core/kmm_front.sv]
`default_nettype none
module kmm_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [1:0]              action,
	input  wire logic [5:0]              position,
	input  wire logic [7:0]              symbol,
	input  wire logic [kmm_pkg::CNT_W-1:0] len_eff,
	input  wire logic                    q_full,
	output logic                         q_push,
	output kmm_pkg::kmm_op_t             q_item
);
	import kmm_pkg::*;

	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] fill_next;
	logic             accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		fill_next = fill_q;
		if (action == ACT_RESTART) begin
			fill_next = '0;
		end else if (action == ACT_TEXT && 32'(fill_q) < MAX_PATTERN) begin
			fill_next = fill_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_next;
		end
	end

	assign q_push          = accept && (action == ACT_LOAD || action == ACT_TEXT);
	assign q_item.is_load  = (action == ACT_LOAD);
	assign q_item.position = POS_W'(position);
	assign q_item.symbol   = symbol;
	assign q_item.emit     = (action == ACT_TEXT) && (fill_next >= len_eff);

endmodule
`default_nettype wire

[rtl/core/kmm_queue.sv]
`default_nettype none
module kmm_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire kmm_pkg::kmm_op_t push_item,
	output logic             full,
	input  wire logic        pop,
	output kmm_pkg::kmm_op_t pop_item,
	output logic             not_empty
);
	import kmm_pkg::*;

	kmm_op_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_pop;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_item  = slot_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/kmm_back.sv]
`default_nettype none
module kmm_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire kmm_pkg::kmm_op_t          op,
	input  wire logic                      op_valid,
	output logic                           op_pop,
	input  wire logic [kmm_pkg::CNT_W-1:0] len_eff,
	input  wire logic [kmm_pkg::CFG_W-1:0] threshold,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [6:0]              mismatches
);
	import kmm_pkg::*;

	localparam int VEC_W = SYM_W * MAX_PATTERN;

	logic [VEC_W-1:0]            pat_q;
	logic [VEC_W-1:0]            win_q;
	logic [VEC_W-1:0]            win_next;
	logic [VEC_W-1:0]            pat_shift;
	logic [CNT_W-1:0]            base;
	logic [MAX_PATTERN-1:0]      mm_comb;
	logic [MAX_PATTERN-1:0]      mm_s1;
	logic                        v_s1;
	logic [GRP_CNT_W-1:0]        grp_comb [NGRP];
	logic [GRP_CNT_W-1:0]        grp_s2 [NGRP];
	logic                        v_s2;
	logic [CNT_W-1:0]            total;
	logic                        en;
	logic                        take;
	logic                        out_valid_q;
	logic [6:0]                  mismatches_q;

	assign en     = !out_valid_q || out_ready;
	assign op_pop = en;
	assign take   = en && op_valid;

	// pattern cells and text window
	always_ff @(posedge clk) begin
		if (take && op.is_load && 32'(op.position) < MAX_PATTERN) begin
			pat_q[SYM_W*op.position +: SYM_W] <= op.symbol;
		end
		if (take && !op.is_load) begin
			win_q <= win_next;
		end
	end

	assign win_next  = {op.symbol, win_q[VEC_W-1:SYM_W]};
	assign base      = CNT_W'(MAX_PATTERN) - len_eff;
	assign pat_shift = pat_q << {base, 3'b000};

	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			mm_comb[k] = (k >= 32'(base)) &&
				(pat_shift[SYM_W*k +: SYM_W] != win_next[SYM_W*k +: SYM_W]);
		end
	end

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_comb[g] = '0;
			for (int b = 0; b < GRP_N; b++) begin
				if (g * GRP_N + b < MAX_PATTERN) begin
					grp_comb[g] = grp_comb[g] + GRP_CNT_W'(mm_s1[g * GRP_N + b]);
				end
			end
		end
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < NGRP; g++) begin
			total = total + CNT_W'(grp_s2[g]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mm_s1  <= mm_comb;
			grp_s2 <= grp_comb;
			if (32'(total) >= 32'(threshold) || 32'(total) > FIELD_MAX) begin
				mismatches_q <= '1;
			end else begin
				mismatches_q <= 7'(total);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= take && !op.is_load && op.emit;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign mismatches = signed'(mismatches_q);

endmodule
`default_nettype wire

[rtl/core/k_mismatch_window_matcher_unit.sv]
`default_nettype none
// channel  | signals                            | dir
// ---------+------------------------------------+-----
// in       | in_valid/in_ready action position symbol | in
// out      | out_valid/out_ready mismatches     | out
// cfg      | cfg_wr_en cfg_addr cfg_wdata       | in
//
// A queue beat is taken each cycle while the 2-deep op queue has room.
// Back end retires one op per cycle while the output register is free or drained;
// a text byte's result goes from the queue through the s1, s2 and output registers.
// Stalls at out_ready freeze the whole compare pipeline; the queue absorbs two beats.
// Reset clears window fill, queue and valids; pattern and window contents are undefined.
module k_mismatch_window_matcher_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                action,
	input  wire logic [5:0]                position,
	input  wire logic [7:0]                symbol,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [6:0]              mismatches,
	input  wire logic                      cfg_wr_en,
	input  wire logic [kmm_pkg::IDX_W-1:0] cfg_addr,
	input  wire logic [kmm_pkg::CFG_W-1:0] cfg_wdata
);
	import kmm_pkg::*;

	logic [CFG_W-1:0] len_cfg_q;
	logic [CFG_W-1:0] thr_cfg_q;
	logic [CNT_W-1:0] len_eff;
	logic             q_full;
	logic             q_push;
	kmm_op_t          q_in;
	kmm_op_t          q_out;
	logic             q_pop;
	logic             q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q <= RST_PATTERN_LENGTH;
			thr_cfg_q <= RST_ERROR_THRESHOLD;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_PATTERN_LENGTH:  len_cfg_q <= cfg_wdata;
				REG_ERROR_THRESHOLD: thr_cfg_q <= cfg_wdata;
				default:             len_cfg_q <= len_cfg_q;
			endcase
		end
	end

	assign len_eff = len_clamp(len_cfg_q);

	kmm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.position (position),
		.symbol   (symbol),
		.len_eff  (len_eff),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_in)
	);

	kmm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_out),
		.not_empty (q_not_empty)
	);

	kmm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (q_out),
		.op_valid   (q_not_empty),
		.op_pop     (q_pop),
		.len_eff    (len_eff),
		.threshold  (thr_cfg_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mismatches (mismatches)
	);

endmodule
`default_nettype wire

[sim/k_mismatch_window_matcher_unit_test.sv]
`default_nettype none
module k_mismatch_window_matcher_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import kmm_pkg::*;

	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam int LIMIT  = 1_000_000;
	localparam int ITEMS  = 2000;
	localparam int SETTLE = 16;

	class distance_tracker;
		logic [SYM_W-1:0] pattern [MAX_PATTERN];
		logic [SYM_W-1:0] window [MAX_PATTERN];
		int unsigned fill;
		logic [CFG_W-1:0] length_reg;
		logic [CFG_W-1:0] threshold_reg;
		logic signed [6:0] expected_distance [$];
		int errors;
		int checked;
		int saturated;

		function new();
			fill = 0;
			length_reg = RST_PATTERN_LENGTH;
			threshold_reg = RST_ERROR_THRESHOLD;
			errors = 0;
			checked = 0;
			saturated = 0;
			foreach (pattern[i]) begin
				pattern[i] = '0;
				window[i] = '0;
			end
		endfunction

		function int span();
			if (length_reg == 0)
				return 1;
			if (length_reg > MAX_PATTERN)
				return MAX_PATTERN;
			return length_reg;
		endfunction

		function logic signed [6:0] window_distance();
			int n;
			int cnt;
			n = span();
			cnt = 0;
			for (int i = 0; i < n; i++)
				if (pattern[i] != window[MAX_PATTERN - n + i])
					cnt++;
			if (cnt >= threshold_reg || cnt > FIELD_MAX)
				return -7'sd1;
			return 7'(cnt);
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			if (idx == REG_PATTERN_LENGTH)
				length_reg = v;
			else
				threshold_reg = v;
		endfunction

		function void note_beat(logic [ACT_W-1:0] a, logic [POS_W-1:0] p, logic [SYM_W-1:0] s);
			case (a)
				ACT_LOAD: pattern[p] = s;
				ACT_RESTART: fill = 0;
				ACT_TEXT: begin
					for (int i = 0; i < MAX_PATTERN - 1; i++)
						window[i] = window[i + 1];
					window[MAX_PATTERN - 1] = s;
					if (fill < MAX_PATTERN)
						fill++;
					if (fill >= span())
						expected_distance = {expected_distance, window_distance()};
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_distance(logic signed [6:0] got);
			logic signed [6:0] want;
			if (expected_distance.size() == 0) begin
				report($sformatf("result %0d arrived with nothing pending", got));
				return;
			end
			want = expected_distance.pop_front();
			checked++;
			if (want == -1)
				saturated++;
			if (got !== want)
				report($sformatf("result %0d: got %0d, want %0d", checked, got, want));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [ACT_W-1:0] action;
	logic [POS_W-1:0] position;
	logic [SYM_W-1:0] symbol;
	logic out_valid;
	logic out_ready;
	logic signed [6:0] mismatches;
	logic cfg_wr_en;
	logic [IDX_W-1:0] cfg_addr;
	logic [CFG_W-1:0] cfg_wdata;

	distance_tracker tracker;
	bit calm;
	int beats;
	int phases;
	int cur_len;
	int alphabet;
	int cycles;
	bit [MAX_PATTERN-1:0] loaded;
	logic [SYM_W-1:0] pat_copy [MAX_PATTERN];

	k_mismatch_window_matcher_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.position(position),
		.symbol(symbol),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mismatches(mismatches),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[k_mismatch_window_matcher_unit] ERROR");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [SYM_W-1:0] rand_sym();
		if (alphabet == 256)
			return 8'($urandom_range(0, 255));
		return 8'(8'h61 + $urandom_range(0, alphabet - 1));
	endfunction

	// result side: random back-pressure, check every accepted beat
	initial begin
		int stall;
		stall = 0;
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready = 0;
				stall--;
			end else begin
				out_ready = 1;
				if (!calm)
					stall = pick_gap();
			end
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				tracker.check_distance(mismatches);
		end
	end

	task automatic push_beat(logic [ACT_W-1:0] a, logic [POS_W-1:0] p, logic [SYM_W-1:0] s);
		int g;
		g = calm ? 0 : pick_gap();
		repeat (g) begin
			@(negedge clk);
			in_valid = 0;
		end
		@(negedge clk);
		in_valid = 1;
		action = a;
		position = p;
		symbol = s;
		do @(posedge clk); while (!in_ready);
		tracker.note_beat(a, p, s);
		if (a != ACT_UNUSED)
			beats++;
		if (a == ACT_LOAD) begin
			loaded[p] = 1;
			pat_copy[p] = s;
		end
	endtask

	task automatic push_text(logic [SYM_W-1:0] s);
		push_beat(ACT_TEXT, 6'($urandom), s);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 0;
		while (tracker.expected_distance.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_wr_en = 1;
		cfg_addr = idx;
		cfg_wdata = v;
		@(negedge clk);
		cfg_wr_en = 0;
		tracker.write_reg(idx, v);
	endtask

	task automatic configure(logic [CFG_W-1:0] len, logic [CFG_W-1:0] thr);
		settle();
		write_reg(REG_PATTERN_LENGTH, len);
		write_reg(REG_ERROR_THRESHOLD, thr);
		cur_len = (len == 0) ? 1 : ((len > MAX_PATTERN) ? MAX_PATTERN : len);
		phases++;
	endtask

	// never compare against a pattern slot that was not loaded
	task automatic ensure_pattern();
		for (int i = 0; i < cur_len; i++)
			if (!loaded[i])
				push_beat(ACT_LOAD, 6'(i), rand_sym());
	endtask

	// pattern copy; slots from flip_from on are inverted, the rest mutated at mut_pct
	task automatic stream_copy(int flip_from, int mut_pct);
		logic [SYM_W-1:0] s;
		for (int i = 0; i < cur_len; i++) begin
			s = pat_copy[i];
			if (i >= flip_from)
				s = ~s;
			else if ($urandom_range(1, 100) <= mut_pct)
				s = rand_sym();
			push_text(s);
		end
	endtask

	initial begin
		int r;
		int eff;
		logic [CFG_W-1:0] len;
		logic [CFG_W-1:0] thr;
		tracker = new();
		arst_n = 0;
		in_valid = 0;
		action = ACT_LOAD;
		position = '0;
		symbol = '0;
		cfg_wr_en = 0;
		cfg_addr = REG_PATTERN_LENGTH;
		cfg_wdata = '0;
		calm = 0;
		beats = 0;
		phases = 0;
		loaded = '0;
		alphabet = 256;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		write_reg(REG_PATTERN_LENGTH, 7'd3);
		write_reg(REG_ERROR_THRESHOLD, 7'd4);
		cur_len = 3;
		phases++;
		push_beat(ACT_LOAD, 6'd0, 8'h00);
		push_beat(ACT_LOAD, 6'd1, 8'hFF);
		push_beat(ACT_LOAD, 6'd2, 8'hA5);
		push_beat(ACT_LOAD, 6'd63, 8'hFF);
		push_beat(ACT_TEXT, 6'd0, 8'h00);
		push_beat(ACT_TEXT, 6'd63, 8'hFF);
		push_beat(ACT_TEXT, 6'd0, 8'hA5);
		push_beat(ACT_TEXT, 6'd63, 8'h5A);
		push_beat(ACT_UNUSED, 6'd63, 8'hFF);
		push_beat(ACT_RESTART, 6'd0, 8'h00);
		push_beat(ACT_TEXT, 6'd0, 8'h00);
		push_beat(ACT_LOAD, 6'd1, 8'h00);
		push_beat(ACT_TEXT, 6'd0, 8'hFF);
		push_beat(ACT_TEXT, 6'd0, 8'hA5);
		configure(7'd3, 7'd0);
		push_beat(ACT_TEXT, 6'd0, 8'h00);
		configure(7'd0, 7'd2);
		push_beat(ACT_TEXT, 6'd0, 8'h00);
		push_beat(ACT_TEXT, 6'd0, 8'h01);

		// full-length windows: 64 differences, then 63
		configure(7'd127, 7'd127);
		ensure_pattern();
		push_beat(ACT_RESTART, 6'd0, 8'h00);
		stream_copy(0, 0);
		configure(7'd64, 7'd64);
		push_beat(ACT_RESTART, 6'd0, 8'h00);
		stream_copy(1, 0);

		while (beats < ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				len = 7'($urandom_range(1, 8));
			else if (r < 82)
				len = 7'($urandom_range(9, 24));
			else if (r < 90)
				len = 7'd64;
			else if (r < 95)
				len = 7'd0;
			else
				len = 7'($urandom_range(65, 127));
			eff = (len == 0) ? 1 : ((len > MAX_PATTERN) ? MAX_PATTERN : len);
			case ($urandom_range(0, 7))
				0: thr = 7'd0;
				1: thr = 7'd1;
				2: thr = 7'(eff / 2);
				3: thr = 7'(eff);
				4: thr = 7'(eff + 1);
				5: thr = 7'd64;
				6: thr = 7'd127;
				default: thr = 7'($urandom_range(0, 127));
			endcase
			configure(len, thr);
			calm = ($urandom_range(0, 4) == 0);
			alphabet = ($urandom_range(0, 3) == 0) ? 256 : 4;
			ensure_pattern();
			repeat ($urandom_range(3, 8)) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					if ($urandom_range(0, 1))
						push_beat(ACT_RESTART, 6'($urandom), rand_sym());
					repeat ($urandom_range(0, 3)) push_text(rand_sym());
					stream_copy(cur_len, $urandom_range(0, 20));
				end else if (r < 65) begin
					stream_copy($urandom_range(0, cur_len - 1), 0);
				end else if (r < 82) begin
					repeat ($urandom_range(1, 10)) push_text(rand_sym());
				end else if (r < 90) begin
					push_beat(ACT_LOAD, 6'($urandom), rand_sym());
				end else if (r < 95) begin
					push_beat(ACT_UNUSED, 6'($urandom), 8'($urandom));
				end else begin
					push_beat(ACT_RESTART, 6'($urandom), 8'($urandom));
				end
			end
		end

		settle();
		$display("ran %0d input beats across %0d register settings", beats, phases);
		$display("checked %0d distances, %0d of them over threshold", tracker.checked,
			tracker.saturated);
		if (tracker.errors == 0)
			$display("[k_mismatch_window_matcher_unit] OK");
		else
			$display("[k_mismatch_window_matcher_unit] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
